// ----- design/flic_pkg.sv -----
package flic_pkg;

    localparam int ADDR_BITS = 22;
    localparam int DIM_BITS  = 12;
    localparam int LEN_BITS  = 9;
    localparam int QDEPTH    = 4;
    localparam int QPTR_BITS = 2;

    localparam logic [1:0] KIND_BRUN = 2'd0;
    localparam logic [1:0] KIND_LC   = 2'd1;
    localparam logic [1:0] KIND_SS2  = 2'd2;
    localparam logic [1:0] KIND_COPY = 2'd3;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_PITCH  = 2'd2;

    localparam logic [15:0] OP_SKIP_MASK = 16'hC000;
    localparam logic [15:0] OP_LAST_BIT  = 16'h8000;

    typedef struct packed {
        logic [DIM_BITS-1:0] width;
        logic [DIM_BITS-1:0] height;
        logic [DIM_BITS-1:0] pitch;
    } cfg_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] addr;
        logic [15:0]          value;
        logic [LEN_BITS-1:0]  len;
        logic                 word;
    } cmd_t;

endpackage

// ----- design/flic_in_if.sv -----
interface flic_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       chunk_start;
    logic [1:0] chunk_kind;

    modport source (output valid, data_byte, chunk_start, chunk_kind, input ready);
    modport sink (input valid, data_byte, chunk_start, chunk_kind, output ready);
endinterface

// ----- design/flic_out_if.sv -----
interface flic_out_if;
    logic        valid;
    logic        ready;
    logic [21:0] write_addr;
    logic [15:0] write_value;
    logic [8:0]  write_len;
    logic        word_pattern;
    logic        beyond_frame;

    modport source (output valid, write_addr, write_value, write_len, word_pattern,
                    beyond_frame, input ready);
    modport sink (input valid, write_addr, write_value, write_len, word_pattern,
                  beyond_frame, output ready);
endinterface

// ----- design/flic_frame_chunk_decoder.sv -----
// FLIC image chunk decoder (byte run, byte delta, word delta, raw copy).
// in_ch carries one payload byte per request; chunk_start on the first byte
// of a chunk selects chunk_kind and restarts decoding at any point.
// out_ch carries frame buffer write requests: address, byte or word value,
// length in bytes, word-replicate flag and a flag for writes past
// pitch*height.
// cfg_we/cfg_index/cfg_data set width, height and pitch; write them only
// while no chunk is in flight.
// Throughput: one byte per cycle while the queue is not full. The parser
// updates its state in the accept cycle and pushes at most one command
// into a 4-entry queue. A command passes through the queue and then the
// output register of flic_emit before it is offered on out_ch.
// If out_ch stalls the queue fills, and in_ch.ready drops when it is full.
// Reset clears the parser to wait for a chunk start, empties the queue and
// loads width 320, height 200, pitch 0 (pitch 0 uses the width).
module flic_frame_chunk_decoder
    import flic_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    flic_in_if.sink             in_ch,
    flic_out_if.source          out_ch,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [DIM_BITS-1:0] cfg_data
);

    cfg_t        cfg_reg;
    logic [23:0] limit_reg;
    logic [DIM_BITS-1:0] pitch;
    logic        acc;
    logic        push;
    cmd_t        cmd;
    logic        pop;
    logic        not_full;
    logic        not_empty;
    cmd_t        head;

    assign pitch       = (cfg_reg.pitch != '0) ? cfg_reg.pitch : cfg_reg.width;
    assign in_ch.ready = not_full;
    assign acc         = in_ch.valid && not_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg   <= '{12'd320, 12'd200, 12'd0};
            limit_reg <= 24'd64000;
        end
        else
        begin
            limit_reg <= 24'(pitch) * 24'(cfg_reg.height);
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WIDTH:  cfg_reg.width  <= cfg_data;
                    REG_HEIGHT: cfg_reg.height <= cfg_data;
                    REG_PITCH:  cfg_reg.pitch  <= cfg_data;
                    default:    ;
                endcase
            end
        end
    end

    flic_parse u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .acc         (acc),
        .data_byte   (in_ch.data_byte),
        .chunk_start (in_ch.chunk_start),
        .chunk_kind  (in_ch.chunk_kind),
        .push        (push),
        .cmd         (cmd)
    );

    flic_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (cmd),
        .pop       (pop),
        .not_full  (not_full),
        .not_empty (not_empty),
        .head      (head)
    );

    flic_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_limit (limit_reg),
        .q_valid     (not_empty),
        .q_head      (head),
        .pop         (pop),
        .out_ch      (out_ch)
    );

endmodule

// ----- design/flic_parse.sv -----
module flic_parse
    import flic_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       acc,
    input  logic [7:0] data_byte,
    input  logic       chunk_start,
    input  logic [1:0] chunk_kind,
    output logic       push,
    output cmd_t       cmd
);

    typedef enum logic [23:0] {
        ST_IDLE  = 24'd1 << 0,
        ST_BHDR  = 24'd1 << 1,
        ST_BCNT  = 24'd1 << 2,
        ST_BRUN  = 24'd1 << 3,
        ST_BLIT  = 24'd1 << 4,
        ST_LSKLO = 24'd1 << 5,
        ST_LSKHI = 24'd1 << 6,
        ST_LNLO  = 24'd1 << 7,
        ST_LNHI  = 24'd1 << 8,
        ST_LPKTS = 24'd1 << 9,
        ST_LPSKP = 24'd1 << 10,
        ST_LPCNT = 24'd1 << 11,
        ST_LLIT  = 24'd1 << 12,
        ST_LRUN  = 24'd1 << 13,
        ST_SNLO  = 24'd1 << 14,
        ST_SNHI  = 24'd1 << 15,
        ST_SOPLO = 24'd1 << 16,
        ST_SOPHI = 24'd1 << 17,
        ST_SPSKP = 24'd1 << 18,
        ST_SPCNT = 24'd1 << 19,
        ST_SLIT  = 24'd1 << 20,
        ST_SWLO  = 24'd1 << 21,
        ST_SWHI  = 24'd1 << 22,
        ST_CDATA = 24'd1 << 23
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic [ADDR_BITS-1:0] line_base_reg, line_base_next;
    logic [ADDR_BITS-1:0] cursor_reg, cursor_next;
    logic [15:0]          lines_reg, lines_next;
    logic [15:0]          packets_reg, packets_next;
    logic [11:0]          bytes_reg, bytes_next;
    logic [11:0]          column_reg, column_next;
    logic [7:0]           low_reg, low_next;
    logic [7:0]           run_reg, run_next;

    logic [DIM_BITS-1:0]  pitch;
    logic [15:0]          word_in;
    logic [15:0]          skip_lines;
    logic [31:0]          mul_a;
    logic [12:0]          col_sum;
    logic [8:0]           col_add;
    logic                 do_pkt;
    logic                 do_end;
    phase_t               pkt_ph;
    phase_t               end_ph;

    assign pitch      = (cfg.pitch != '0) ? cfg.pitch : cfg.width;
    assign word_in    = {data_byte, low_reg};
    assign skip_lines = 16'(17'h10000 - {1'b0, word_in});

    always_comb
    begin
        phase_next     = phase_reg;
        line_base_next = line_base_reg;
        cursor_next    = cursor_reg;
        lines_next     = lines_reg;
        packets_next   = packets_reg;
        bytes_next     = bytes_reg;
        column_next    = column_reg;
        low_next       = low_reg;
        run_next       = run_reg;
        push           = 1'b0;
        cmd            = '0;
        col_add        = '0;
        do_pkt         = 1'b0;
        do_end         = 1'b0;
        pkt_ph         = ST_IDLE;
        end_ph         = ST_IDLE;
        mul_a          = '0;
        col_sum        = '0;

        if (chunk_start)
        begin
            line_base_next = '0;
            cursor_next    = '0;
            lines_next     = '0;
            packets_next   = '0;
            bytes_next     = '0;
            column_next    = '0;
            low_next       = '0;
            run_next       = '0;
            unique case (chunk_kind)
                KIND_BRUN:
                begin
                    lines_next = 16'(cfg.height);
                    phase_next = (cfg.height != '0) ? ST_BHDR : ST_IDLE;
                end
                KIND_LC:  phase_next = ST_LSKLO;
                KIND_SS2: phase_next = ST_SNLO;
                default:
                begin
                    lines_next = 16'(cfg.height);
                    phase_next = (cfg.height != '0 && cfg.width != '0) ? ST_CDATA : ST_IDLE;
                end
            endcase
        end

        unique case (phase_next)
            ST_BHDR:
            begin
                column_next = '0;
                cursor_next = line_base_next;
                if (cfg.width == '0)
                begin
                    do_end = 1'b1;
                    end_ph = ST_BHDR;
                end
                else
                    phase_next = ST_BCNT;
            end
            ST_BCNT:
            begin
                if (data_byte != '0)
                begin
                    if (!data_byte[7])
                    begin
                        run_next   = data_byte;
                        phase_next = ST_BRUN;
                    end
                    else
                    begin
                        bytes_next = 12'(9'h100 - {1'b0, data_byte});
                        phase_next = ST_BLIT;
                    end
                end
            end
            ST_BRUN, ST_BLIT:
            begin
                push    = 1'b1;
                cmd     = '{cursor_next, {8'h00, data_byte}, 9'd1, 1'b0};
                col_add = 9'd1;
                if (phase_next == ST_BRUN)
                begin
                    cmd.len = 9'(run_next);
                    col_add = 9'(run_next);
                end
                cursor_next = cursor_next + ADDR_BITS'(col_add);
                col_sum     = 13'(column_next) + 13'(col_add);
                column_next = col_sum[12] ? 12'hFFF : col_sum[11:0];
                if (phase_next == ST_BLIT && bytes_next != '0)
                    bytes_next = bytes_next - 12'd1;
                if (phase_next == ST_BRUN || bytes_next == '0)
                begin
                    if (column_next >= cfg.width)
                    begin
                        do_end = 1'b1;
                        end_ph = ST_BHDR;
                    end
                    else
                        phase_next = ST_BCNT;
                end
            end
            ST_LSKLO:
            begin
                low_next   = data_byte;
                phase_next = ST_LSKHI;
            end
            ST_LSKHI:
            begin
                mul_a          = 32'(pitch) * 32'(word_in);
                line_base_next = mul_a[ADDR_BITS-1:0];
                phase_next     = ST_LNLO;
            end
            ST_LNLO, ST_SNLO, ST_SOPLO, ST_SWLO:
            begin
                low_next = data_byte;
                unique case (phase_next)
                    ST_LNLO:  phase_next = ST_LNHI;
                    ST_SNLO:  phase_next = ST_SNHI;
                    ST_SOPLO: phase_next = ST_SOPHI;
                    default:  phase_next = ST_SWHI;
                endcase
            end
            ST_LNHI, ST_SNHI:
            begin
                lines_next = word_in;
                if (word_in == '0)
                    phase_next = ST_IDLE;
                else
                    phase_next = (phase_next == ST_LNHI) ? ST_LPKTS : ST_SOPLO;
            end
            ST_LPKTS:
            begin
                packets_next = 16'(data_byte);
                cursor_next  = line_base_next;
                if (data_byte == '0)
                begin
                    do_end = 1'b1;
                    end_ph = ST_LPKTS;
                end
                else
                    phase_next = ST_LPSKP;
            end
            ST_LPSKP, ST_SPSKP:
            begin
                cursor_next = cursor_next + ADDR_BITS'(data_byte);
                phase_next  = (phase_next == ST_LPSKP) ? ST_LPCNT : ST_SPCNT;
            end
            ST_LPCNT, ST_SPCNT:
            begin
                if (data_byte == '0)
                    do_pkt = 1'b1;
                else if (!data_byte[7])
                begin
                    if (phase_next == ST_LPCNT)
                    begin
                        bytes_next = 12'(data_byte);
                        phase_next = ST_LLIT;
                    end
                    else
                    begin
                        bytes_next = {3'b000, data_byte, 1'b0};
                        phase_next = ST_SLIT;
                    end
                end
                else
                begin
                    run_next   = 8'(9'h100 - {1'b0, data_byte});
                    phase_next = (phase_next == ST_LPCNT) ? ST_LRUN : ST_SWLO;
                end
                if (phase_next == ST_LPCNT || phase_next == ST_LLIT || phase_next == ST_LRUN)
                begin
                    pkt_ph = ST_LPSKP;
                    end_ph = ST_LPKTS;
                end
                else
                begin
                    pkt_ph = ST_SPSKP;
                    end_ph = ST_SOPLO;
                end
            end
            ST_LLIT, ST_SLIT:
            begin
                push        = 1'b1;
                cmd         = '{cursor_next, {8'h00, data_byte}, 9'd1, 1'b0};
                cursor_next = cursor_next + ADDR_BITS'(1);
                if (bytes_next != '0)
                    bytes_next = bytes_next - 12'd1;
                do_pkt = (bytes_next == '0);
                pkt_ph = (phase_next == ST_LLIT) ? ST_LPSKP : ST_SPSKP;
                end_ph = (phase_next == ST_LLIT) ? ST_LPKTS : ST_SOPLO;
            end
            ST_LRUN:
            begin
                push        = 1'b1;
                cmd         = '{cursor_next, {8'h00, data_byte}, 9'(run_next), 1'b0};
                cursor_next = cursor_next + ADDR_BITS'(run_next);
                do_pkt      = 1'b1;
                pkt_ph      = ST_LPSKP;
                end_ph      = ST_LPKTS;
            end
            ST_SWHI:
            begin
                push        = 1'b1;
                cmd         = '{cursor_next, word_in, {run_next, 1'b0}, 1'b1};
                cursor_next = cursor_next + ADDR_BITS'({run_next, 1'b0});
                do_pkt      = 1'b1;
                pkt_ph      = ST_SPSKP;
                end_ph      = ST_SOPLO;
            end
            ST_SOPHI:
            begin
                if ((word_in & OP_SKIP_MASK) == OP_SKIP_MASK)
                begin
                    mul_a          = 32'(pitch) * 32'(skip_lines);
                    line_base_next = line_base_next + mul_a[ADDR_BITS-1:0];
                    phase_next     = ST_SOPLO;
                end
                else if ((word_in & OP_LAST_BIT) != '0)
                begin
                    push       = 1'b1;
                    cmd        = '{line_base_next + ADDR_BITS'(cfg.width) - ADDR_BITS'(1),
                                   {8'h00, low_reg}, 9'd1, 1'b0};
                    phase_next = ST_SOPLO;
                end
                else
                begin
                    packets_next = word_in;
                    cursor_next  = line_base_next;
                    if (word_in == '0)
                    begin
                        do_end = 1'b1;
                        end_ph = ST_SOPLO;
                    end
                    else
                        phase_next = ST_SPSKP;
                end
            end
            ST_CDATA:
            begin
                push        = 1'b1;
                cmd         = '{line_base_next + ADDR_BITS'(column_next),
                                {8'h00, data_byte}, 9'd1, 1'b0};
                col_sum     = 13'(column_next) + 13'd1;
                column_next = col_sum[12] ? 12'hFFF : col_sum[11:0];
                if (column_next >= cfg.width)
                begin
                    column_next = '0;
                    do_end      = 1'b1;
                    end_ph      = ST_CDATA;
                end
            end
            default: phase_next = ST_IDLE;
        endcase

        if (do_pkt)
        begin
            if (packets_next <= 16'd1)
            begin
                packets_next = '0;
                do_end       = 1'b1;
            end
            else
            begin
                packets_next = packets_next - 16'd1;
                phase_next   = pkt_ph;
            end
        end
        if (do_end)
        begin
            line_base_next = line_base_next + ADDR_BITS'(pitch);
            if (lines_next <= 16'd1)
            begin
                lines_next = '0;
                phase_next = ST_IDLE;
            end
            else
            begin
                lines_next = lines_next - 16'd1;
                phase_next = end_ph;
            end
        end
        push = push && acc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= ST_IDLE;
            line_base_reg <= '0;
            cursor_reg    <= '0;
            lines_reg     <= '0;
            packets_reg   <= '0;
            bytes_reg     <= '0;
            column_reg    <= '0;
            low_reg       <= '0;
            run_reg       <= '0;
        end
        else if (acc)
        begin
            phase_reg     <= phase_next;
            line_base_reg <= line_base_next;
            cursor_reg    <= cursor_next;
            lines_reg     <= lines_next;
            packets_reg   <= packets_next;
            bytes_reg     <= bytes_next;
            column_reg    <= column_next;
            low_reg       <= low_next;
            run_reg       <= run_next;
        end
    end

endmodule

// ----- design/flic_queue.sv -----
module flic_queue
    import flic_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic not_full,
    output logic not_empty,
    output cmd_t head
);

    cmd_t                 slot_reg [QDEPTH];
    logic [QPTR_BITS-1:0] wr_reg, rd_reg;
    logic [QPTR_BITS:0]   count_reg;

    assign not_full  = count_reg < (QPTR_BITS+1)'(QDEPTH);
    assign not_empty = count_reg != '0;
    assign head      = slot_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + QPTR_BITS'(1);
            if (pop)
                rd_reg <= rd_reg + QPTR_BITS'(1);
            if (push && !pop)
                count_reg <= count_reg + (QPTR_BITS+1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (QPTR_BITS+1)'(1);
        end
    end

endmodule

// ----- design/flic_emit.sv -----
module flic_emit
    import flic_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [23:0] frame_limit,
    input  logic        q_valid,
    input  cmd_t        q_head,
    output logic        pop,
    flic_out_if.source  out_ch
);

    logic        valid_reg;
    cmd_t        cmd_reg;
    logic        beyond_reg;
    logic [32:0] end_addr;

    assign pop      = q_valid && (!valid_reg || out_ch.ready);
    assign end_addr = 33'(q_head.addr) + 33'(q_head.len);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!valid_reg || out_ch.ready)
            valid_reg <= q_valid;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg    <= q_head;
            beyond_reg <= end_addr > 33'(frame_limit);
        end
    end

    assign out_ch.valid        = valid_reg;
    assign out_ch.write_addr   = 22'(cmd_reg.addr);
    assign out_ch.write_value  = cmd_reg.value;
    assign out_ch.write_len    = cmd_reg.len;
    assign out_ch.word_pattern = cmd_reg.word;
    assign out_ch.beyond_frame = beyond_reg;

endmodule
